// ----- hdl/mta_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths, weights and register codes for the MLP ticket advisor.
// No dependencies; every other file in hdl/ imports this package.
package mta_pkg;

    // Default saturation limits for the feature scaling
    localparam int unsigned WINDOW_LIMIT_DEF = 1024;
    localparam int unsigned QUEUE_LIMIT_DEF  = 64;

    localparam int unsigned NFEAT = 5;
    localparam int unsigned NHID  = 4;

    // Feature index within the feature vector
    localparam int unsigned FEAT_RUN   = 0;
    localparam int unsigned FEAT_SLEEP = 1;
    localparam int unsigned FEAT_IO    = 2;
    localparam int unsigned FEAT_WAIT  = 3;
    localparam int unsigned FEAT_QUEUE = 4;

    localparam int unsigned FEAT_W      = 17;  // Q16 value in 0..65536
    localparam int unsigned WEIGHT_W    = 18;
    localparam int unsigned PROD_W      = 19;  // floor-shifted hidden product
    localparam int unsigned HID_W       = 21;  // hidden accumulator
    localparam int unsigned OPROD_W     = 20;  // floor-shifted output product
    localparam int unsigned Z_W         = 22;  // output neuron sum
    localparam int unsigned S_W         = 19;  // sigmoid argument inside the clamp
    localparam int unsigned SQ_W        = 20;
    localparam int unsigned INNER_W     = 17;
    localparam int unsigned TPROD_W     = 19;
    localparam int unsigned TICKET_W    = 16;
    localparam int unsigned WIN_W       = 16;
    localparam int unsigned TICK_W      = 32;
    localparam int unsigned COUNT_W     = 8;

    localparam int unsigned IN_TDATA_W  = 120;
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned CFG_IDX_W   = 4;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKET_FLOOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TICKET_CEILING = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] TICKET_FLOOR_RST   = 16'd20;
    localparam logic [CFG_DATA_W-1:0] TICKET_CEILING_RST = 16'd400;

    // Sigmoid constants (Q16)
    localparam logic signed [Z_W-1:0] SIG_HI      = 22'sd262144;
    localparam logic signed [Z_W-1:0] SIG_LO      = -22'sd262144;
    localparam logic [10:0]           SIG_CUBE_K  = 11'd1365;
    localparam logic [14:0]           SIG_QUARTER = 15'd16384;
    localparam logic [16:0]           SIG_HALF    = 17'd32768;
    localparam logic [FEAT_W-1:0]     FAVOR_ONE   = 17'd65536;

    typedef logic signed [WEIGHT_W-1:0] weight_t;

    localparam weight_t HID_WEIGHT [NHID][NFEAT] = '{
        '{-18'sd52429,  18'sd65536,  18'sd45875,  18'sd13107, -18'sd13107},
        '{-18'sd19661,  18'sd39322,  18'sd13107,  18'sd58982, -18'sd6554 },
        '{-18'sd72090,  18'sd6554,   18'sd0,      18'sd6554,  -18'sd26214},
        '{-18'sd13107,  18'sd13107,  18'sd58982,  18'sd6554,  -18'sd13107}
    };

    localparam weight_t OUT_WEIGHT [NHID] = '{
        18'sd32768, 18'sd32768, 18'sd26214, 18'sd39322
    };

    // Input transaction, last field in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] runnable_count;
        logic [TICK_W-1:0]  now_tick;
        logic [TICK_W-1:0]  last_run_tick;
        logic [WIN_W-1:0]   io_window;
        logic [WIN_W-1:0]   sleep_window;
        logic [WIN_W-1:0]   run_window;
    } sample_t;

    typedef struct packed {
        logic [WIN_W-1:0] io;
        logic [WIN_W-1:0] sleep;
        logic [WIN_W-1:0] run;
    } decay_t;

    // Output transaction, last field in the lowest bits
    typedef struct packed {
        logic [6:0]          pad;
        logic [WIN_W-1:0]    io_decayed;
        logic [WIN_W-1:0]    sleep_decayed;
        logic [WIN_W-1:0]    run_decayed;
        logic [FEAT_W-1:0]   favor_q16;
        logic [TICKET_W-1:0] ticket_count;
    } result_t;

    typedef logic [NFEAT-1:0][FEAT_W-1:0] feat_vec_t;

endpackage

// ----- hdl/mlp_ticket_advisor_top.sv -----
`timescale 1ns / 1ps
// Top level of the MLP ticket advisor: config registers, feature, network and ticket pipelines.
// Depends on mta_pkg, mta_feature, mta_mlp and mta_ticket.
//
//  Channel  | Signals                          | Transaction moves
//  ---------+----------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tdata        | one process record
//  output   | m_tvalid m_tready m_tdata        | tickets, probability, decayed windows
//  config   | cfg_valid cfg_ready cfg_index    | one write to ticket_floor or ticket_ceiling
//           | cfg_data                         |
//
// One transaction per cycle sustained while m_tready is high; input acceptance reaches m_tvalid
// through the 4 feature stages, 4 network stages and 5 sigmoid and ticket stages.
// rst_n clears all valid bits and loads ticket_floor = 20, ticket_ceiling = 400.
// Each stage has its own valid bit and advances when empty or when the stage after it advances,
// so bubbles close up under m_tready low and no transaction is dropped or repeated.
// cfg_ready is always high; unknown register indexes are ignored.
module mlp_ticket_advisor_top #(
    parameter int unsigned WINDOW_LIMIT = mta_pkg::WINDOW_LIMIT_DEF,
    parameter int unsigned QUEUE_LIMIT  = mta_pkg::QUEUE_LIMIT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // run_window, sleep_window, io_window, last_run_tick, now_tick, runnable_count
    input  logic [mta_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ticket_count, favor_q16, run_decayed, sleep_decayed, io_decayed, zero pad
    output logic [mta_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mta_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mta_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mta_pkg::*;

    logic [CFG_DATA_W-1:0] ticket_floor_reg;
    logic [CFG_DATA_W-1:0] ticket_ceiling_reg;

    sample_t               sample;
    feat_vec_t             feat;
    decay_t                feat_decay;
    decay_t                mlp_decay;
    decay_t                out_decay;
    logic                  feat_valid, feat_ready;
    logic                  mlp_valid, mlp_ready;
    logic signed [Z_W-1:0] z;
    logic [TICKET_W-1:0]   ticket_count;
    logic [FEAT_W-1:0]     favor_q16;
    result_t               result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_floor_reg   <= TICKET_FLOOR_RST;
            ticket_ceiling_reg <= TICKET_CEILING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TICKET_FLOOR:
                begin
                    ticket_floor_reg <= cfg_data;
                end
                REG_TICKET_CEILING:
                begin
                    ticket_ceiling_reg <= cfg_data;
                end
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    assign sample = sample_t'(s_tdata);

    mta_feature #(
        .WINDOW_LIMIT (WINDOW_LIMIT),
        .QUEUE_LIMIT  (QUEUE_LIMIT)
    ) u_feature (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (sample),
        .out_valid (feat_valid),
        .out_ready (feat_ready),
        .feat      (feat),
        .decay     (feat_decay)
    );

    mta_mlp u_mlp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (feat_valid),
        .in_ready  (feat_ready),
        .feat      (feat),
        .decay_in  (feat_decay),
        .out_valid (mlp_valid),
        .out_ready (mlp_ready),
        .z         (z),
        .decay_out (mlp_decay)
    );

    mta_ticket u_ticket (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (mlp_valid),
        .in_ready       (mlp_ready),
        .z              (z),
        .decay_in       (mlp_decay),
        .ticket_floor   (ticket_floor_reg),
        .ticket_ceiling (ticket_ceiling_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .ticket_count   (ticket_count),
        .favor_q16      (favor_q16),
        .decay_out      (out_decay)
    );

    assign result.pad           = '0;
    assign result.io_decayed    = out_decay.io;
    assign result.sleep_decayed = out_decay.sleep;
    assign result.run_decayed   = out_decay.run;
    assign result.favor_q16     = favor_q16;
    assign result.ticket_count  = ticket_count;

    assign m_tdata = result;

endmodule

// ----- hdl/mta_scale.sv -----
`timescale 1ns / 1ps
// One saturating feature scaler: round(min(v, LIMIT) * 65536 / LIMIT) over four stages.
// Division by LIMIT is a reciprocal multiply plus one correction step. Uses mta_pkg.
module mta_scale #(
    parameter int unsigned LIMIT = 1024,
    parameter int unsigned IN_W  = 16
) (
    input  logic                      clk,
    input  logic [3:0]                stage_en,
    input  logic [IN_W-1:0]           value,
    output logic [mta_pkg::FEAT_W-1:0] feat
);
    import mta_pkg::*;

    localparam int unsigned MW    = $clog2(LIMIT + 1);
    localparam int unsigned NW    = MW + 16;
    localparam int unsigned CW    = (IN_W > MW) ? IN_W : MW;
    localparam int unsigned HALF  = LIMIT / 2;
    localparam longint unsigned RECIP = (64'd1 << NW) / LIMIT;
    localparam int unsigned RW    = $clog2(RECIP + 1);
    localparam int unsigned PW    = FEAT_W + MW;

    logic [CW-1:0]      value_ext;
    logic [MW-1:0]      m_reg, m_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [NW+RW-1:0]   est_prod;
    logic [FEAT_W-1:0]  q_reg, q_next;
    logic [NW-1:0]      n3_reg;
    logic [FEAT_W-1:0]  q3_reg;
    logic [PW-1:0]      p_reg, p_next;
    logic [NW-1:0]      rem;
    logic [FEAT_W-1:0]  feat_reg, feat_next;

    assign value_ext = CW'(value);
    assign m_next    = (value_ext > CW'(LIMIT)) ? MW'(LIMIT) : value_ext[MW-1:0];

    // Estimate is the true quotient or one below it
    assign n_next   = {m_reg, 16'd0} + NW'(HALF);
    assign est_prod = n_next * RW'(RECIP);
    assign q_next   = est_prod[NW +: FEAT_W];

    assign p_next = q_reg * MW'(LIMIT);

    assign rem       = n3_reg - p_reg[NW-1:0];
    assign feat_next = q3_reg + FEAT_W'(rem >= NW'(LIMIT));

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            m_reg <= m_next;
        end
        if (stage_en[1])
        begin
            n_reg <= n_next;
            q_reg <= q_next;
        end
        if (stage_en[2])
        begin
            n3_reg <= n_reg;
            q3_reg <= q_reg;
            p_reg  <= p_next;
        end
        if (stage_en[3])
        begin
            feat_reg <= feat_next;
        end
    end

    assign feat = feat_reg;

endmodule

// ----- hdl/mta_feature.sv -----
`timescale 1ns / 1ps
// Feature front end: wrapped wait, five saturating scalers and 7/8 window decay.
// Four pipeline stages with a ready chain. Uses mta_pkg and mta_scale.
module mta_feature #(
    parameter int unsigned WINDOW_LIMIT = mta_pkg::WINDOW_LIMIT_DEF,
    parameter int unsigned QUEUE_LIMIT  = mta_pkg::QUEUE_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mta_pkg::sample_t   in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output mta_pkg::feat_vec_t feat,
    output mta_pkg::decay_t    decay
);
    import mta_pkg::*;

    localparam int unsigned NSTAGE = 4;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;
    logic [TICK_W-1:0] waited;
    decay_t            decay_next;
    decay_t            decay_reg [NSTAGE];

    function automatic logic [WIN_W-1:0] decay7_8(input logic [WIN_W-1:0] w);
        logic [WIN_W+2:0] t;
        t = {3'b000, w} * 19'd7;
        return t[WIN_W+2:3];
    endfunction

    always_comb
    begin
        en[3] = !valid_reg[3] || out_ready;
        en[2] = !valid_reg[2] || en[3];
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (en[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
        end
    end

    // Wait wraps modulo 2^32
    assign waited = in_item.now_tick - in_item.last_run_tick;

    assign decay_next.run   = decay7_8(in_item.run_window);
    assign decay_next.sleep = decay7_8(in_item.sleep_window);
    assign decay_next.io    = decay7_8(in_item.io_window);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            decay_reg[0] <= decay_next;
        end
        if (en[1])
        begin
            decay_reg[1] <= decay_reg[0];
        end
        if (en[2])
        begin
            decay_reg[2] <= decay_reg[1];
        end
        if (en[3])
        begin
            decay_reg[3] <= decay_reg[2];
        end
    end

    assign decay = decay_reg[NSTAGE-1];

    mta_scale #(.LIMIT(WINDOW_LIMIT), .IN_W(WIN_W)) u_scale_run (
        .clk      (clk),
        .stage_en (en),
        .value    (in_item.run_window),
        .feat     (feat[FEAT_RUN])
    );

    mta_scale #(.LIMIT(WINDOW_LIMIT), .IN_W(WIN_W)) u_scale_sleep (
        .clk      (clk),
        .stage_en (en),
        .value    (in_item.sleep_window),
        .feat     (feat[FEAT_SLEEP])
    );

    mta_scale #(.LIMIT(WINDOW_LIMIT), .IN_W(WIN_W)) u_scale_io (
        .clk      (clk),
        .stage_en (en),
        .value    (in_item.io_window),
        .feat     (feat[FEAT_IO])
    );

    mta_scale #(.LIMIT(WINDOW_LIMIT), .IN_W(TICK_W)) u_scale_wait (
        .clk      (clk),
        .stage_en (en),
        .value    (waited),
        .feat     (feat[FEAT_WAIT])
    );

    mta_scale #(.LIMIT(QUEUE_LIMIT), .IN_W(COUNT_W)) u_scale_queue (
        .clk      (clk),
        .stage_en (en),
        .value    (in_item.runnable_count),
        .feat     (feat[FEAT_QUEUE])
    );

endmodule

// ----- hdl/mta_mlp.sv -----
`timescale 1ns / 1ps
// Fixed 5-4-1 network: hidden products, leaky ReLU sums, output products, output sum.
// Four pipeline stages with a ready chain. Uses mta_pkg weights and widths.
module mta_mlp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  mta_pkg::feat_vec_t         feat,
    input  mta_pkg::decay_t            decay_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [mta_pkg::Z_W-1:0] z,
    output mta_pkg::decay_t            decay_out
);
    import mta_pkg::*;

    localparam int unsigned NSTAGE = 4;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    logic signed [WEIGHT_W+FEAT_W:0]    hprod_full [NHID][NFEAT];
    logic signed [PROD_W-1:0]           prod_reg   [NHID][NFEAT];
    logic signed [PROD_W-1:0]           prod_next  [NHID][NFEAT];
    logic signed [HID_W-1:0]            acc        [NHID];
    logic signed [HID_W-1:0]            hid_reg    [NHID];
    logic signed [HID_W-1:0]            hid_next   [NHID];
    logic signed [WEIGHT_W+HID_W-1:0]   oprod_full [NHID];
    logic signed [OPROD_W-1:0]          oprod_reg  [NHID];
    logic signed [OPROD_W-1:0]          oprod_next [NHID];
    logic signed [Z_W-1:0]              z_reg, z_next;
    decay_t                             decay_reg  [NSTAGE];

    always_comb
    begin
        en[3] = !valid_reg[3] || out_ready;
        en[2] = !valid_reg[2] || en[3];
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (en[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
        end
    end

    // Hidden products, floor-shifted by 16
    always_comb
    begin
        for (int k = 0; k < NHID; k++)
        begin
            for (int j = 0; j < NFEAT; j++)
            begin
                hprod_full[k][j] = HID_WEIGHT[k][j] * $signed({1'b0, feat[j]});
                prod_next[k][j]  = PROD_W'(hprod_full[k][j] >>> 16);
            end
        end
    end

    // Hidden sums with leaky ReLU: negative values floor-shift by 3
    always_comb
    begin
        for (int k = 0; k < NHID; k++)
        begin
            acc[k] = '0;
            for (int j = 0; j < NFEAT; j++)
            begin
                acc[k] = acc[k] + HID_W'(prod_reg[k][j]);
            end
            hid_next[k] = acc[k][HID_W-1] ? (acc[k] >>> 3) : acc[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NHID; k++)
        begin
            oprod_full[k] = OUT_WEIGHT[k] * hid_reg[k];
            oprod_next[k] = OPROD_W'(oprod_full[k] >>> 16);
        end
    end

    always_comb
    begin
        z_next = '0;
        for (int k = 0; k < NHID; k++)
        begin
            z_next = z_next + Z_W'(oprod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg     <= prod_next;
            decay_reg[0] <= decay_in;
        end
        if (en[1])
        begin
            hid_reg      <= hid_next;
            decay_reg[1] <= decay_reg[0];
        end
        if (en[2])
        begin
            oprod_reg    <= oprod_next;
            decay_reg[2] <= decay_reg[1];
        end
        if (en[3])
        begin
            z_reg        <= z_next;
            decay_reg[3] <= decay_reg[2];
        end
    end

    assign z         = z_reg;
    assign decay_out = decay_reg[NSTAGE-1];

endmodule

// ----- hdl/mta_ticket.sv -----
`timescale 1ns / 1ps
// Clamped cubic sigmoid and ticket mapping, five pipeline stages, last one is the output register.
// Uses mta_pkg constants; ticket bounds come from the top-level registers.
module mta_ticket (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [mta_pkg::Z_W-1:0]     z,
    input  mta_pkg::decay_t                    decay_in,
    input  logic [mta_pkg::CFG_DATA_W-1:0]     ticket_floor,
    input  logic [mta_pkg::CFG_DATA_W-1:0]     ticket_ceiling,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mta_pkg::TICKET_W-1:0]       ticket_count,
    output logic [mta_pkg::FEAT_W-1:0]         favor_q16,
    output mta_pkg::decay_t                    decay_out
);
    import mta_pkg::*;

    localparam int unsigned NSTAGE = 5;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;
    decay_t            decay_reg [NSTAGE];

    // Stage 0: clamp flags and square
    logic                     lo_next, hi_next;
    logic signed [S_W-1:0]    s_next;
    logic signed [2*S_W-1:0]  sq_full;
    logic [SQ_W-1:0]          sq_next;
    logic                     lo0_reg, hi0_reg;
    logic signed [S_W-1:0]    s0_reg;
    logic [SQ_W-1:0]          sq_reg;

    // Stage 1: inner term
    logic [SQ_W+10:0]         cube;
    logic signed [INNER_W-1:0] inner_next;
    logic                     lo1_reg, hi1_reg;
    logic signed [S_W-1:0]    s1_reg;
    logic signed [INNER_W-1:0] inner_reg;

    // Stage 2: probability
    logic signed [S_W+INNER_W-1:0] yprod;
    logic signed [20:0]       y;
    logic [FEAT_W-1:0]        favor_next;
    logic [FEAT_W-1:0]        favor2_reg;

    // Stage 3: scaled span
    logic signed [CFG_DATA_W:0]       span;
    logic signed [FEAT_W+CFG_DATA_W+1:0] tprod;
    logic signed [TPROD_W-1:0]        tp_next;
    logic signed [TPROD_W-1:0]        tp_reg;
    logic [FEAT_W-1:0]                favor3_reg;

    // Stage 4: tickets
    logic signed [TPROD_W-1:0] tsum;
    logic [TICKET_W-1:0]       ticket_next;
    logic [TICKET_W-1:0]       ticket_reg;
    logic [FEAT_W-1:0]         favor4_reg;

    always_comb
    begin
        en[4] = !valid_reg[4] || out_ready;
        en[3] = !valid_reg[3] || en[4];
        en[2] = !valid_reg[2] || en[3];
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (en[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
            if (en[4])
            begin
                valid_reg[4] <= valid_reg[3];
            end
        end
    end

    assign lo_next = (z <= SIG_LO);
    assign hi_next = (z >= SIG_HI);
    assign s_next  = z[S_W-1:0];
    assign sq_full = s_next * s_next;
    assign sq_next = sq_full[SQ_W+15:16];

    assign cube       = sq_reg * SIG_CUBE_K;
    assign inner_next = $signed({2'b00, SIG_QUARTER}) - $signed({2'b00, cube[SQ_W+10:16]});

    assign yprod = s1_reg * inner_reg;
    assign y     = $signed({4'b0000, SIG_HALF}) + 21'(yprod >>> 16);

    always_comb
    begin
        if (lo1_reg)
        begin
            favor_next = '0;
        end
        else if (hi1_reg)
        begin
            favor_next = FAVOR_ONE;
        end
        else if (y < 0)
        begin
            favor_next = '0;
        end
        else if (y > $signed({4'b0000, FAVOR_ONE}))
        begin
            favor_next = FAVOR_ONE;
        end
        else
        begin
            favor_next = y[FEAT_W-1:0];
        end
    end

    // Span may be negative when the ceiling sits below the floor
    assign span    = $signed({1'b0, ticket_ceiling}) - $signed({1'b0, ticket_floor});
    assign tprod   = $signed({1'b0, favor2_reg}) * span;
    assign tp_next = TPROD_W'(tprod >>> 16);

    assign tsum        = $signed({3'b000, ticket_floor}) + tp_reg;
    assign ticket_next = (tsum < 1) ? TICKET_W'(1) : tsum[TICKET_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo0_reg      <= lo_next;
            hi0_reg      <= hi_next;
            s0_reg       <= s_next;
            sq_reg       <= sq_next;
            decay_reg[0] <= decay_in;
        end
        if (en[1])
        begin
            lo1_reg      <= lo0_reg;
            hi1_reg      <= hi0_reg;
            s1_reg       <= s0_reg;
            inner_reg    <= inner_next;
            decay_reg[1] <= decay_reg[0];
        end
        if (en[2])
        begin
            favor2_reg   <= favor_next;
            decay_reg[2] <= decay_reg[1];
        end
        if (en[3])
        begin
            tp_reg       <= tp_next;
            favor3_reg   <= favor2_reg;
            decay_reg[3] <= decay_reg[2];
        end
        if (en[4])
        begin
            ticket_reg   <= ticket_next;
            favor4_reg   <= favor3_reg;
            decay_reg[4] <= decay_reg[3];
        end
    end

    assign ticket_count = ticket_reg;
    assign favor_q16    = favor4_reg;
    assign decay_out    = decay_reg[NSTAGE-1];

endmodule
